// File: rtl/core/frec_pkg.sv
// shared types and constants for the framed record envelope checker
package frec_pkg;

    localparam int POS_W = 33;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] HDR_POS = 33'd24;
    localparam logic [31:0] HDR_LIMIT = 32'd24;

    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

    localparam logic [7:0] MAGIC_WORD [4] = '{8'h53, 8'h57, 8'h4D, 8'h50};

    localparam logic [15:0] PROTOCOL_RESET = 16'd1;
    localparam logic [31:0] MAX_TOTAL_RESET = 32'd65536;

    typedef enum logic [0:0] {
        REG_PROTOCOL_NUMBER = 1'b0,
        REG_MAX_TOTAL_BYTES = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_LIMIT     = 3'd1,
        ST_TRUNCATED = 3'd2,
        ST_MAGIC     = 3'd3,
        ST_VERSION   = 3'd4,
        ST_INVALID   = 3'd5,
        ST_TRAILING  = 3'd6,
        ST_CHECKSUM  = 3'd7
    } status_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       done_res;
        status_t    status;
    } frec_result_t;

endpackage

// File: rtl/core/frec_hash.sv
// one fnv-1a 64-bit step, prime multiply as shift-add
module frec_hash (
    input  logic [63:0] hash_in,
    input  logic [7:0]  data_byte,
    output logic [63:0] hash_out
);
    import frec_pkg::*;

    logic [63:0] mixed;

    // prime is 2^40 + 2^8 + 0xb3
    always_comb
    begin
        mixed = hash_in ^ {56'd0, data_byte};
        hash_out = (mixed << 40) + (mixed << 8) + (mixed << 7) + (mixed << 5)
                 + (mixed << 4) + (mixed << 1) + mixed;
    end

endmodule

// File: rtl/core/frec_core.sv
// envelope capture, payload hashing and final status for one byte per cycle while advance is high
module frec_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    input  logic [15:0]           protocol_number,
    input  logic [31:0]           max_total_bytes,
    output frec_pkg::frec_result_t result
);
    import frec_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             magic_bad_reg, magic_bad_next;
    logic [15:0]      protocol_seen_reg, protocol_seen_next;
    logic [15:0]      reserved_seen_reg, reserved_seen_next;
    logic [63:0]      declared_length_reg, declared_length_next;
    logic [63:0]      expected_hash_reg, expected_hash_next;
    logic [63:0]      running_hash_reg, running_hash_next;

    logic [63:0]      hash_step;
    logic [POS_W-1:0] body_pos;
    logic [POS_W-1:0] body_size;
    logic             in_payload;
    status_t          final_status;

    frec_hash u_hash (
        .hash_in  (running_hash_reg),
        .data_byte(data_byte),
        .hash_out (hash_step)
    );

    always_comb
    begin
        magic_bad_next       = magic_bad_reg;
        protocol_seen_next   = protocol_seen_reg;
        reserved_seen_next   = reserved_seen_reg;
        declared_length_next = declared_length_reg;
        expected_hash_next   = expected_hash_reg;
        running_hash_next    = running_hash_reg;
        in_payload           = 1'b0;
        body_pos             = pos_reg - HDR_POS;

        if (pos_reg < 33'd4)
        begin
            magic_bad_next = magic_bad_reg | (data_byte != MAGIC_WORD[pos_reg[1:0]]);
        end
        else if (pos_reg < 33'd6)
        begin
            protocol_seen_next[{pos_reg[0], 3'b000} +: 8] = data_byte;
        end
        else if (pos_reg < 33'd8)
        begin
            reserved_seen_next[{pos_reg[0], 3'b000} +: 8] = data_byte;
        end
        else if (pos_reg < 33'd16)
        begin
            declared_length_next[{pos_reg[2:0], 3'b000} +: 8] = data_byte;
        end
        else if (pos_reg < HDR_POS)
        begin
            expected_hash_next[{pos_reg[2:0], 3'b000} +: 8] = data_byte;
        end
        else if ({31'd0, body_pos} < declared_length_reg)
        begin
            in_payload        = 1'b1;
            running_hash_next = hash_step;
        end

        // counter holds at all ones
        pos_next  = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 33'd1;
        body_size = pos_next - HDR_POS;
    end

    // first failing check wins
    always_comb
    begin
        if (max_total_bytes < HDR_LIMIT)
            final_status = ST_INVALID;
        else if (pos_next > {1'b0, max_total_bytes})
            final_status = ST_LIMIT;
        else if (pos_next < HDR_POS)
            final_status = ST_TRUNCATED;
        else if (magic_bad_next)
            final_status = ST_MAGIC;
        else if (declared_length_next > {32'd0, max_total_bytes - HDR_LIMIT})
            final_status = ST_LIMIT;
        else if (protocol_seen_next != protocol_number)
            final_status = ST_VERSION;
        else if (reserved_seen_next != 16'd0)
            final_status = ST_INVALID;
        else if (declared_length_next > {31'd0, body_size})
            final_status = ST_TRUNCATED;
        else if (declared_length_next < {31'd0, body_size})
            final_status = ST_TRAILING;
        else if (running_hash_next != expected_hash_next)
            final_status = ST_CHECKSUM;
        else
            final_status = ST_OK;
    end

    always_comb
    begin
        result.payload_valid = in_payload;
        result.payload_byte  = in_payload ? data_byte : 8'd0;
        result.done_res      = last_byte;
        result.status        = last_byte ? final_status : ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg             <= '0;
            magic_bad_reg       <= 1'b0;
            protocol_seen_reg   <= '0;
            reserved_seen_reg   <= '0;
            declared_length_reg <= '0;
            expected_hash_reg   <= '0;
            running_hash_reg    <= FNV_BASIS;
        end
        else if (advance)
        begin
            if (last_byte)
            begin
                pos_reg             <= '0;
                magic_bad_reg       <= 1'b0;
                protocol_seen_reg   <= '0;
                reserved_seen_reg   <= '0;
                declared_length_reg <= '0;
                expected_hash_reg   <= '0;
                running_hash_reg    <= FNV_BASIS;
            end
            else
            begin
                pos_reg             <= pos_next;
                magic_bad_reg       <= magic_bad_next;
                protocol_seen_reg   <= protocol_seen_next;
                reserved_seen_reg   <= reserved_seen_next;
                declared_length_reg <= declared_length_next;
                expected_hash_reg   <= expected_hash_next;
                running_hash_reg    <= running_hash_next;
            end
        end
    end

    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_byte |=> pos_reg == '0 && running_hash_reg == FNV_BASIS)
        else $error("state not cleared after final byte");

    a_pos_grows: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !last_byte |=> pos_reg >= $past(pos_reg) && pos_reg != '0)
        else $error("byte counter went backwards");

    a_payload_after_header: assert property (@(posedge clk) disable iff (!rst_n)
        result.payload_valid |-> pos_reg >= HDR_POS)
        else $error("payload flagged inside envelope");

endmodule

// File: rtl/core/framed_record_envelope_checker_top.sv
// top level: config registers, input register and result register around the checker
// Takes one byte of an encoded buffer per transfer and returns one result per byte,
// with a sustained rate of one byte per clock cycle while result_ready stays high. The
// result is registered: the byte is held in an input register, goes through one
// combinational pass (envelope capture, the fnv-1a multiply done as a shift-add, and
// the status checks) and lands in a result register once that register is free.
// A new byte is taken while a result still waits.
// payload bytes appear with payload_valid set; the byte marked last carries done_res and
// the status code, after which the checker is ready for a new buffer. protocol_number sits
// at address 0 and max_total_bytes at address 4; write them only while no bytes are in flight.
module framed_record_envelope_checker_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output logic                result_valid,
    input  logic                result_ready,
    output logic                payload_valid,
    output logic [7:0]          payload_byte,
    output logic                done_res,
    output logic [2:0]          status
);
    import frec_pkg::*;

    logic [15:0]  protocol_number_reg, protocol_number_next;
    logic [31:0]  max_total_bytes_reg, max_total_bytes_next;
    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    logic         out_valid_reg, out_valid_next;
    frec_result_t out_result_reg;
    frec_result_t core_result;
    logic         out_free;
    logic         advance;
    logic         cfg_write;
    reg_index_t   cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_index = reg_index_t'(paddr[2]);

    always_comb
    begin
        protocol_number_next = protocol_number_reg;
        max_total_bytes_next = max_total_bytes_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_PROTOCOL_NUMBER: protocol_number_next = pwdata[15:0];
                REG_MAX_TOTAL_BYTES: max_total_bytes_next = pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_PROTOCOL_NUMBER: prdata = {16'd0, protocol_number_reg};
            REG_MAX_TOTAL_BYTES: prdata = max_total_bytes_reg;
            default:             prdata = 32'd0;
        endcase
    end

    // the pipeline moves when the result register is free or being emptied
    assign out_free   = !out_valid_reg || result_ready;
    assign advance    = in_valid_reg && out_free;
    assign item_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item_valid && item_ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
    end

    frec_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .data_byte      (in_byte_reg),
        .last_byte      (in_last_reg),
        .protocol_number(protocol_number_reg),
        .max_total_bytes(max_total_bytes_reg),
        .result         (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            protocol_number_reg <= PROTOCOL_RESET;
            max_total_bytes_reg <= MAX_TOTAL_RESET;
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            protocol_number_reg <= protocol_number_next;
            max_total_bytes_reg <= max_total_bytes_next;
            in_valid_reg        <= in_valid_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
        if (advance)
            out_result_reg <= core_result;
    end

    assign result_valid  = out_valid_reg;
    assign payload_valid = out_result_reg.payload_valid;
    assign payload_byte  = out_result_reg.payload_byte;
    assign done_res      = out_result_reg.done_res;
    assign status        = out_result_reg.status;

    a_status_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !done_res |-> status == ST_OK)
        else $error("status given on a byte that is not final");

    a_byte_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !payload_valid |-> payload_byte == 8'd0)
        else $error("byte passed outside payload");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg)
            && $stable(in_last_reg))
        else $error("held input byte lost");

endmodule

// File: bench/tb.sv
// testbench for the framed record envelope checker: random and directed buffers, predicted per byte
module tb;
    import frec_pkg::*;

    localparam logic [63:0] ENVELOPE_BYTES = 64'd24;
    localparam logic [63:0] FNV_OFFSET     = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] FNV_PRIME      = 64'd1099511628211;
    localparam logic [31:0] MAGIC_LE       = 32'h504D_5753;
    localparam int          LONG_STALL     = 400;
    localparam int          WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] value;
        logic       is_last;
    } stream_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic [7:0]  data_byte = '0;
    logic        last_byte = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        done_res;
    logic [2:0]  status;

    // predictor copy of the registers and the envelope state
    logic [15:0] cfg_protocol = PROTOCOL_RESET;
    logic [31:0] cfg_max_bytes = MAX_TOTAL_RESET;
    logic [32:0] pos_count = '0;
    logic        magic_mismatch = 1'b0;
    logic [15:0] proto_field = '0;
    logic [15:0] rsvd_field = '0;
    logic [63:0] length_field = '0;
    logic [63:0] hash_field = '0;
    logic [63:0] payload_hash = FNV_OFFSET;

    stream_byte_t tx_bytes [$];
    logic [7:0]   frame_q [$];
    frec_result_t pending_results [$];
    stream_byte_t next_byte;
    frec_result_t want_res;

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int rx_hold_req = 0;
    int rx_hold_seen = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int bytes_queued = 0;
    int bytes_sent = 0;
    int results_seen = 0;
    int settings_used = 0;
    int mismatch_count = 0;
    int status_hits [8] = '{default: 0};

    always #2 clk = ~clk;

    framed_record_envelope_checker_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .payload_valid(payload_valid),
        .payload_byte (payload_byte),
        .done_res     (done_res),
        .status       (status)
    );

    function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
        return (h ^ {56'b0, b}) * FNV_PRIME;
    endfunction

    function automatic status_t buffer_verdict(input logic [32:0] nbytes);
        logic [63:0] limit;
        logic [63:0] total;
        limit = {32'b0, cfg_max_bytes};
        total = {31'b0, nbytes};
        if (limit < ENVELOPE_BYTES) return ST_INVALID;
        if (total > limit) return ST_LIMIT;
        if (total < ENVELOPE_BYTES) return ST_TRUNCATED;
        if (magic_mismatch) return ST_MAGIC;
        if (length_field > limit - ENVELOPE_BYTES) return ST_LIMIT;
        if (proto_field != cfg_protocol) return ST_VERSION;
        if (rsvd_field != 16'h0) return ST_INVALID;
        if (length_field > total - ENVELOPE_BYTES) return ST_TRUNCATED;
        if (length_field < total - ENVELOPE_BYTES) return ST_TRAILING;
        if (payload_hash != hash_field) return ST_CHECKSUM;
        return ST_OK;
    endfunction

    function automatic frec_result_t predict_byte_result(input logic [7:0] b, input logic is_last);
        frec_result_t r;
        logic [32:0] nbytes;
        r = '0;
        if (pos_count < 4)
        begin
            if (b != MAGIC_LE[8*pos_count[1:0] +: 8]) magic_mismatch = 1'b1;
        end
        else if (pos_count < 6)
            proto_field[8*pos_count[0] +: 8] = b;
        else if (pos_count < 8)
            rsvd_field[8*pos_count[0] +: 8] = b;
        else if (pos_count < 16)
            length_field[8*pos_count[2:0] +: 8] = b;
        else if (pos_count < ENVELOPE_BYTES)
            hash_field[8*pos_count[2:0] +: 8] = b;
        else if ({31'b0, pos_count} - ENVELOPE_BYTES < length_field)
        begin
            r.payload_valid = 1'b1;
            r.payload_byte = b;
            payload_hash = fnv_fold(payload_hash, b);
        end
        // counter holds at all ones
        nbytes = (pos_count == '1) ? pos_count : pos_count + 33'd1;
        pos_count = nbytes;
        r.done_res = is_last;
        r.status = ST_OK;
        if (is_last)
        begin
            r.status = buffer_verdict(nbytes);
            pos_count = '0;
            magic_mismatch = 1'b0;
            proto_field = '0;
            rsvd_field = '0;
            length_field = '0;
            hash_field = '0;
            payload_hash = FNV_OFFSET;
        end
        return r;
    endfunction

    task automatic build_frame(input logic [15:0] proto, input logic [15:0] rsvd,
                               input logic [63:0] decl, input int body_len, input bit good_hash);
        logic [63:0] h;
        logic [7:0]  b;
        int          k;
        h = FNV_OFFSET;
        frame_q.delete();
        for (int i = 0; i < 4; i++) frame_q.push_back(MAGIC_LE[8*i +: 8]);
        for (int i = 0; i < 2; i++) frame_q.push_back(proto[8*i +: 8]);
        for (int i = 0; i < 2; i++) frame_q.push_back(rsvd[8*i +: 8]);
        for (int i = 0; i < 8; i++) frame_q.push_back(decl[8*i +: 8]);
        for (int i = 0; i < 8; i++) frame_q.push_back(8'h00);
        for (int i = 0; i < body_len; i++)
        begin
            b = 8'($urandom);
            frame_q.push_back(b);
            if (i < decl) h = fnv_fold(h, b);
        end
        if (!good_hash)
        begin
            k = $urandom_range(63, 0);
            h[k] = ~h[k];
        end
        for (int i = 0; i < 8; i++) frame_q[16+i] = h[8*i +: 8];
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) tx_bytes.push_back('{frame_q[i], i == frame_q.size() - 1});
        bytes_queued += frame_q.size();
    endtask

    task automatic queue_random_buffer();
        int          kind;
        int          body;
        int          k;
        logic [15:0] proto;
        logic [15:0] rsvd;
        logic [63:0] decl;
        bit          good;
        kind = $urandom_range(99, 0);
        body = ($urandom_range(9, 0) == 0) ? $urandom_range(120, 40) : $urandom_range(12, 0);
        if ($urandom_range(3, 0) == 0) body = 0;
        proto = cfg_protocol;
        rsvd = '0;
        decl = 64'(body);
        good = 1'b1;
        if (kind >= 94)
        begin
            frame_q.delete();
            k = $urandom_range(30, 1);
            repeat (k) frame_q.push_back(8'($urandom));
        end
        else
        begin
            if (kind >= 50 && kind < 56)
                proto = cfg_protocol ^ 16'($urandom_range(65535, 1));
            else if (kind >= 56 && kind < 62)
                rsvd = 16'($urandom_range(65535, 1));
            else if (kind >= 62 && kind < 68)
                good = 1'b0;
            else if (kind >= 68 && kind < 74)
                decl = 64'(body + $urandom_range(5, 1));
            else if (kind >= 74 && kind < 80)
            begin
                if (body == 0) body = 3;
                decl = 64'($urandom_range(body - 1, 0));
            end
            else if (kind >= 80 && kind < 85)
            begin
                // either far out of range or one past the limit
                if ($urandom_range(1, 0) == 1)
                    decl = {$urandom, $urandom} | 64'h1_0000_0000;
                else
                    decl = {32'b0, cfg_max_bytes} - 64'd23;
            end
            build_frame(proto, rsvd, decl, body, good);
            if (kind >= 85 && kind < 90)
            begin
                k = $urandom_range(3, 0);
                frame_q[k] ^= 8'($urandom_range(255, 1));
            end
            else if (kind >= 90)
            begin
                k = $urandom_range(23, 1);
                while (frame_q.size() > k) void'(frame_q.pop_back());
            end
        end
        send_frame();
    endtask

    task automatic fill_random(input int budget);
        int target;
        target = bytes_queued + budget;
        while (bytes_queued < target) queue_random_buffer();
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (tx_bytes.size() != 0 || item_valid || pending_results.size() != 0);
    endtask

    task automatic apb_write(input reg_index_t idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_PROTOCOL_NUMBER: cfg_protocol = value[15:0];
            REG_MAX_TOTAL_BYTES: cfg_max_bytes = value;
            default: ;
        endcase
    endtask

    task automatic set_phase(input logic [15:0] proto, input logic [31:0] max_bytes,
                             input int src_pct, input int snk_pct);
        wait_drained();
        apb_write(REG_PROTOCOL_NUMBER, {16'h0, proto});
        apb_write(REG_MAX_TOTAL_BYTES, max_bytes);
        @(negedge clk);
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        settings_used++;
    endtask

    // sender: one transfer at a time from tx_bytes, predicted on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                pending_results.push_back(predict_byte_result(data_byte, last_byte));
                bytes_sent++;
            end
            if (!item_valid || item_ready)
            begin
                if (tx_bytes.size() != 0 && $urandom_range(99, 0) >= src_idle_pct)
                begin
                    next_byte = tx_bytes.pop_front();
                    item_valid <= 1'b1;
                    data_byte <= next_byte.value;
                    last_byte <= next_byte.is_last;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result transfer, random and long stalls on ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with no prediction waiting");
                    mismatch_count++;
                end
                else
                begin
                    want_res = pending_results.pop_front();
                    results_seen++;
                    if (payload_valid !== want_res.payload_valid)
                    begin
                        $error("payload_valid: expected %0d, actual %0d",
                               want_res.payload_valid, payload_valid);
                        mismatch_count++;
                    end
                    if (payload_byte !== want_res.payload_byte)
                    begin
                        $error("payload_byte: expected %0h, actual %0h",
                               want_res.payload_byte, payload_byte);
                        mismatch_count++;
                    end
                    if (done_res !== want_res.done_res)
                    begin
                        $error("done_res: expected %0d, actual %0d", want_res.done_res, done_res);
                        mismatch_count++;
                    end
                    if (status !== want_res.status)
                    begin
                        $error("status: expected %0d, actual %0d", want_res.status, status);
                        mismatch_count++;
                    end
                    if (want_res.done_res) status_hits[want_res.status]++;
                end
            end
            if (rx_hold_seen != rx_hold_req)
            begin
                rx_hold_seen <= rx_hold_req;
                stall_left <= LONG_STALL;
                result_ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= ($urandom_range(99, 0) >= snk_stall_pct);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("FAIL framed_record_envelope_checker_top");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed buffers under the reset register values
        @(negedge clk);
        tx_bytes.push_back('{8'h00, 1'b0});
        tx_bytes.push_back('{8'hFF, 1'b1});
        bytes_queued += 2;
        build_frame(16'h0001, 16'h0000, 64'd0, 0, 1'b1);
        send_frame();
        build_frame(16'h0001, 16'h0000, 64'd3, 3, 1'b1);
        send_frame();
        build_frame(16'h0001, 16'h0000, 64'd0, 0, 1'b1);
        frame_q[2] ^= 8'h80;
        send_frame();
        build_frame(16'hFFFF, 16'h0000, 64'd1, 1, 1'b1);
        send_frame();
        build_frame(16'h0001, 16'h8000, 64'd0, 0, 1'b1);
        send_frame();
        build_frame(16'h0001, 16'h0000, 64'd2, 2, 1'b0);
        send_frame();
        build_frame(16'h0001, 16'h0000, 64'd4, 2, 1'b1);
        send_frame();
        build_frame(16'h0001, 16'h0000, 64'd1, 3, 1'b1);
        send_frame();
        build_frame(16'h0001, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b1);
        send_frame();
        build_frame(16'h0001, 16'h0000, 64'd0, 0, 1'b1);
        while (frame_q.size() > 10) void'(frame_q.pop_back());
        send_frame();

        // no idling, then a long receiver hold while the sender keeps offering
        set_phase(16'h0001, 32'd65536, 0, 0);
        fill_random(100);
        rx_hold_req++;

        set_phase(16'hFFFF, 32'hFFFF_FFFF, 58, 0);
        fill_random(80);

        // smallest legal limit: only an empty payload fits
        set_phase(16'h0000, 32'd24, 0, 58);
        build_frame(16'h0000, 16'h0000, 64'd0, 0, 1'b1);
        send_frame();
        build_frame(16'h0000, 16'h0000, 64'd1, 1, 1'b1);
        send_frame();
        fill_random(60);

        set_phase(16'($urandom), 32'($urandom_range(200, 24)), 15, 15);
        fill_random(70);

        // limits below the envelope size
        set_phase(16'($urandom), 32'd23, 0, 0);
        build_frame(cfg_protocol, 16'h0000, 64'd0, 0, 1'b1);
        send_frame();
        fill_random(30);

        set_phase(16'h0001, 32'd0, 15, 15);
        fill_random(25);

        set_phase(PROTOCOL_RESET, MAX_TOTAL_RESET, 15, 15);
        fill_random(60);

        wait_drained();
        repeat (8) @(posedge clk);
        $display("covered %0d bytes, %0d results, %0d register settings",
                 bytes_sent, results_seen, settings_used);
        $display("status counts, ok to checksum: %0d %0d %0d %0d %0d %0d %0d %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4], status_hits[5], status_hits[6], status_hits[7]);
        if (mismatch_count == 0)
            $display("PASS framed_record_envelope_checker_top");
        else
            $display("FAIL framed_record_envelope_checker_top");
        $finish;
    end

endmodule

// File: framed_record_envelope_checker_top.f
rtl/core/frec_pkg.sv
rtl/core/frec_hash.sv
rtl/core/frec_core.sv
rtl/core/framed_record_envelope_checker_top.sv
bench/tb.sv
